// ----- design/ptst_pkg.sv -----
`default_nettype none
package ptst_pkg;

    localparam int unsigned NUM_BASES = 7;
    localparam int unsigned NUM_SMALL = 9;

    typedef logic [63:0] word_t;

    // front-end classification of one candidate
    typedef struct packed {
        logic  decided;   // result known without Miller-Rabin
        logic  verdict;   // result when decided
        word_t n;
        word_t d;         // odd part of n-1
        logic [5:0] s;    // power of two in n-1
    } job_t;

    function automatic word_t base_of(input logic [2:0] idx);
        word_t b;
        case (idx)
            3'd0: b = 64'd2;
            3'd1: b = 64'd325;
            3'd2: b = 64'd9375;
            3'd3: b = 64'd28178;
            3'd4: b = 64'd450775;
            3'd5: b = 64'd9780504;
            3'd6: b = 64'd1795265022;
            default: b = 64'd2;
        endcase
        return b;
    endfunction

    function automatic logic [4:0] small_prime(input logic [3:0] idx);
        logic [4:0] p;
        case (idx)
            4'd0: p = 5'd2;
            4'd1: p = 5'd3;
            4'd2: p = 5'd5;
            4'd3: p = 5'd7;
            4'd4: p = 5'd11;
            4'd5: p = 5'd13;
            4'd6: p = 5'd17;
            4'd7: p = 5'd19;
            4'd8: p = 5'd23;
            default: p = 5'd2;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- design/ptst_front.sv -----
`default_nettype none
// Screens a candidate: below two, small prime, small factor; otherwise
// splits n-1 into d * 2^s. Residues by the small primes are built one
// 4-bit digit a cycle, then the trailing-zero scan runs on d.
module ptst_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [63:0]   s_number,
    output logic               job_valid,
    input  wire logic          job_ready,
    output ptst_pkg::job_t     job
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RES  = 2'd1;
    localparam logic [1:0] ST_TZ   = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [63:0] n_reg;
    logic [63:0] d_reg;
    logic [5:0]  s_reg;
    logic [3:0]  dig_reg;
    logic [4:0]  rem_reg [ptst_pkg::NUM_SMALL];
    logic        decided_reg, verdict_reg;

    logic [3:0]  digit;
    logic [4:0]  rem_new [ptst_pkg::NUM_SMALL];
    logic        any_zero, any_eq;

    assign digit = n_reg[63 - 4*dig_reg -: 4];

    always_comb begin
        logic [8:0] v;
        logic [8:0] p;
        for (int i = 0; i < ptst_pkg::NUM_SMALL; i++) begin
            p = 9'(ptst_pkg::small_prime(4'(i)));
            v = {rem_reg[i], 4'b0} | 9'(digit);
            // v < 16*p: compare and subtract 8p, 4p, 2p, p
            for (int k = 3; k >= 0; k--) begin
                if (v >= (p << k)) v = v - (p << k);
            end
            rem_new[i] = v[4:0];
        end
    end

    always_comb begin
        any_zero = 1'b0;
        any_eq = 1'b0;
        for (int i = 0; i < ptst_pkg::NUM_SMALL; i++) begin
            if (rem_reg[i] == 5'd0) any_zero = 1'b1;
            if (n_reg == 64'(ptst_pkg::small_prime(4'(i)))) any_eq = 1'b1;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign job_valid = (state_reg == ST_OUT);
    assign job.decided = decided_reg;
    assign job.verdict = verdict_reg;
    assign job.n = n_reg;
    assign job.d = d_reg;
    assign job.s = s_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_RES;
            ST_RES:  if (dig_reg == 4'd15) state_next = ST_TZ;
            ST_TZ:   if (decided_reg || d_reg[0]) state_next = ST_OUT;
            ST_OUT:  if (job_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        case (state_reg)
            ST_IDLE: begin
                n_reg   <= s_number;
                d_reg   <= s_number - 64'd1;
                s_reg   <= 6'd0;
                dig_reg <= 4'd0;
                for (int i = 0; i < ptst_pkg::NUM_SMALL; i++) rem_reg[i] <= 5'd0;
                decided_reg <= 1'b0;
                verdict_reg <= 1'b0;
            end
            ST_RES: begin
                dig_reg <= dig_reg + 4'd1;
                for (int i = 0; i < ptst_pkg::NUM_SMALL; i++) rem_reg[i] <= rem_new[i];
            end
            ST_TZ: begin
                if (!decided_reg) begin
                    if (n_reg < 64'd2) begin
                        decided_reg <= 1'b1;
                        verdict_reg <= 1'b0;
                    end else if (any_eq) begin
                        decided_reg <= 1'b1;
                        verdict_reg <= 1'b1;
                    end else if (any_zero) begin
                        decided_reg <= 1'b1;
                        verdict_reg <= 1'b0;
                    end else if (!d_reg[0]) begin
                        d_reg <= {1'b0, d_reg[63:1]};
                        s_reg <= s_reg + 6'd1;
                    end
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ----- design/ptst_queue.sv -----
`default_nettype none
// Two-entry job queue between screening and the Miller-Rabin engine.
module ptst_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  ptst_pkg::job_t   in_job,
    output logic             out_valid,
    input  wire logic        out_ready,
    output ptst_pkg::job_t   out_job
);
    ptst_pkg::job_t mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
        if (push) mem_reg[wr_reg] <= in_job;
    end
endmodule
`default_nettype wire

// ----- design/ptst_mulmod.sv -----
`default_nettype none
// (x * y) mod m by double-and-add, one bit of y per cycle.
// Inputs x, y must already be below m.
module ptst_mulmod (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] x,
    input  wire logic [63:0] y,
    input  wire logic [63:0] m,
    output logic             done,
    output logic [63:0]      result
);
    logic        busy_reg;
    logic [5:0]  bit_reg;
    logic [63:0] acc_reg, x_reg, y_reg, m_reg;
    logic [64:0] dbl, dsum;
    logic [63:0] acc_d, acc_n;

    // acc < m, so one compare and subtract per add
    assign dbl   = {acc_reg, 1'b0};
    assign acc_d = (dbl >= {1'b0, m_reg}) ? 64'(dbl - {1'b0, m_reg}) : acc_reg << 1;
    assign dsum  = {1'b0, acc_d} + {1'b0, x_reg};
    assign acc_n = y_reg[63] ? ((dsum >= {1'b0, m_reg}) ? 64'(dsum - {1'b0, m_reg})
                                                          : dsum[63:0])
                             : acc_d;
    assign result = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg == 6'd63) begin
                busy_reg <= 1'b0;
                done     <= 1'b1;
            end
        end
        if (start) begin
            acc_reg <= 64'd0;
            bit_reg <= 6'd0;
            x_reg   <= x;
            y_reg   <= y;
            m_reg   <= m;
        end else if (busy_reg) begin
            acc_reg <= acc_n;
            y_reg   <= y_reg << 1;
            bit_reg <= bit_reg + 6'd1;
        end
    end
endmodule
`default_nettype wire

// ----- design/ptst_back.sv -----
`default_nettype none
// Miller-Rabin sequencer over the seven bases on one shared mulmod unit.
module ptst_back (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        job_valid,
    output logic             job_ready,
    input  ptst_pkg::job_t   job,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_is_prime
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_BASE  = 4'd1;
    localparam logic [3:0] ST_RED   = 4'd2;
    localparam logic [3:0] ST_PBIT  = 4'd3;
    localparam logic [3:0] ST_PMUL  = 4'd4;
    localparam logic [3:0] ST_PSQ   = 4'd5;
    localparam logic [3:0] ST_CHK   = 4'd6;
    localparam logic [3:0] ST_SQ    = 4'd7;
    localparam logic [3:0] ST_NEXT  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;
    localparam logic [3:0] ST_WAIT  = 4'd10;

    logic [3:0]  state_reg, state_next;
    logic [3:0]  ret_reg;
    ptst_pkg::job_t j_reg;
    logic [2:0]  bi_reg;
    logic [63:0] b_reg, acc_reg, sq_reg, e_reg;
    logic [5:0]  r_reg;
    logic        res_reg;

    logic        mm_start, mm_done;
    logic [63:0] mm_x, mm_y, mm_res;
    logic [63:0] last;
    logic [64:0] red_t;

    assign last = j_reg.n - 64'd1;
    // b_reg < n, so the shifted partial remainder stays below 2n
    assign red_t = {b_reg, sq_reg[30]};

    ptst_mulmod u_mm (
        .aclk(aclk), .aresetn(aresetn), .start(mm_start),
        .x(mm_x), .y(mm_y), .m(j_reg.n), .done(mm_done), .result(mm_res)
    );

    assign job_ready  = (state_reg == ST_IDLE);
    assign m_valid    = (state_reg == ST_OUT);
    assign m_is_prime = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mm_start  <= 1'b0;
        end else begin
            mm_start <= 1'b0;
            case (state_reg)
                ST_IDLE: if (job_valid) begin
                    j_reg  <= job;
                    bi_reg <= 3'd0;
                    if (job.decided) begin
                        res_reg   <= job.verdict;
                        state_reg <= ST_OUT;
                    end else begin
                        res_reg   <= 1'b1;
                        state_reg <= ST_BASE;
                    end
                end
                ST_BASE: begin
                    // base mod n, one base bit a cycle (bases are below 2^31)
                    sq_reg    <= ptst_pkg::base_of(bi_reg);
                    b_reg     <= 64'd0;
                    r_reg     <= 6'd0;
                    state_reg <= ST_RED;
                end
                ST_RED: begin
                    if (r_reg != 6'd31) begin
                        b_reg  <= (red_t >= {1'b0, j_reg.n}) ? 64'(red_t - {1'b0, j_reg.n})
                                                              : red_t[63:0];
                        sq_reg <= sq_reg << 1;
                        r_reg  <= r_reg + 6'd1;
                    end else if (b_reg == 64'd0) begin
                        state_reg <= ST_NEXT;
                    end else begin
                        acc_reg   <= 64'd1;
                        sq_reg    <= b_reg;
                        e_reg     <= j_reg.d;
                        state_reg <= ST_PBIT;
                    end
                end
                ST_PBIT: begin
                    if (e_reg == 64'd0) begin
                        state_reg <= ST_CHK;
                    end else if (e_reg[0]) begin
                        mm_x <= acc_reg; mm_y <= sq_reg; mm_start <= 1'b1;
                        ret_reg <= ST_PMUL; state_reg <= ST_WAIT;
                    end else begin
                        mm_x <= sq_reg; mm_y <= sq_reg; mm_start <= 1'b1;
                        ret_reg <= ST_PSQ; state_reg <= ST_WAIT;
                    end
                end
                ST_PMUL: begin
                    acc_reg <= mm_res;
                    mm_x <= sq_reg; mm_y <= sq_reg; mm_start <= 1'b1;
                    ret_reg <= ST_PSQ; state_reg <= ST_WAIT;
                end
                ST_PSQ: begin
                    sq_reg    <= mm_res;
                    e_reg     <= e_reg >> 1;
                    state_reg <= ST_PBIT;
                end
                ST_CHK: begin
                    if (acc_reg == 64'd1 || acc_reg == last) begin
                        state_reg <= ST_NEXT;
                    end else begin
                        r_reg     <= 6'd1;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (r_reg >= j_reg.s) begin
                        res_reg   <= 1'b0;
                        state_reg <= ST_OUT;
                    end else begin
                        mm_x <= acc_reg; mm_y <= acc_reg; mm_start <= 1'b1;
                        ret_reg <= ST_NEXT; state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: if (mm_done) begin
                    if (ret_reg == ST_NEXT) begin
                        // squaring in the witness loop
                        acc_reg <= mm_res;
                        r_reg   <= r_reg + 6'd1;
                        state_reg <= (mm_res == last) ? ST_NEXT : ST_SQ;
                        if (mm_res == last) bi_reg <= bi_reg;
                    end else begin
                        state_reg <= ret_reg;
                    end
                end
                ST_NEXT: begin
                    if (bi_reg == 3'(ptst_pkg::NUM_BASES - 1)) begin
                        state_reg <= ST_OUT;
                    end else begin
                        bi_reg    <= bi_reg + 3'd1;
                        state_reg <= ST_BASE;
                    end
                end
                ST_OUT: if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb state_next = state_reg;
    logic unused_ok;
    assign unused_ok = ^state_next;
endmodule
`default_nettype wire

// ----- design/primality_test_64.sv -----
// Deterministic 64-bit primality test (Miller-Rabin, seven fixed bases).
// The front screens each number against the primes 2..23 and, for
// numbers it passes on, strips the factors of two from n-1; a two-entry
// queue then feeds the back, which reduces each base mod n and runs
// modular exponentiation on one bit-serial multiplier. A prime costs up
// to seven bases of about 128 products each; numbers settled by the
// screen skip the Miller-Rabin rounds.
`default_nettype none
module primality_test_64 (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_number,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_is_prime
);
    ptst_pkg::job_t fj, qj;
    logic fv, fr, qv, qr;

    ptst_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_number(s_number), .job_valid(fv), .job_ready(fr), .job(fj)
    );
    ptst_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .in_valid(fv), .in_ready(fr), .in_job(fj),
        .out_valid(qv), .out_ready(qr), .out_job(qj)
    );
    ptst_back u_back (
        .aclk(aclk), .aresetn(aresetn), .job_valid(qv), .job_ready(qr), .job(qj),
        .m_valid(m_valid), .m_ready(m_ready), .m_is_prime(m_is_prime)
    );
endmodule
`default_nettype wire

// ----- design/ptst_checker.sv -----
`default_nettype none
module ptst_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [63:0] s_number,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_is_prime
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_prime)) else $error("out hold");
    a_no_out_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("valid after reset");
    a_in_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready) else $error("not ready after reset");
    a_no_s_ready_rst: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("front takes one at a time");
    logic unused;
    assign unused = ^s_number;
endmodule

bind primality_test_64 ptst_checker u_chk (.*);
`default_nettype wire
